// ===== src/rsf_pkg.sv =====
// Shared types, constants and helpers for the RGB row symmetric FIR.
package rsf_pkg;

   localparam int MAX_TAPS  = 7;
   localparam int MAX_SIDES = MAX_TAPS - 1;
   localparam int WIN_DEPTH = 2 * MAX_TAPS - 1;
   localparam int NUM_CH    = 3;
   localparam int PIX_W     = 8;
   localparam int COEF_W    = 17;
   localparam int FRAC_W    = 16;
   localparam int TAP_W     = 3;
   localparam int CNT_W     = 4;
   localparam int PEND_W    = 3;
   localparam int IDX_W     = 4;
   localparam int PAIR_W    = PIX_W + 1;
   localparam int CPROD_W   = COEF_W + PIX_W;
   localparam int SPROD_W   = COEF_W + PAIR_W;
   localparam int SUM_W     = SPROD_W + 3;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   // register map, index = byte address / 4
   localparam logic [2:0] REG_TAP_COUNT   = 3'd0;
   localparam logic [2:0] REG_COEF_CENTER = 3'd1;
   localparam logic [2:0] REG_COEF_SIDE1  = 3'd2;
   localparam logic [2:0] REG_COEF_SIDE2  = 3'd3;
   localparam logic [2:0] REG_COEF_SIDE3  = 3'd4;
   localparam logic [2:0] REG_COEF_SIDE4  = 3'd5;
   localparam logic [2:0] REG_COEF_SIDE5  = 3'd6;
   localparam logic [2:0] REG_COEF_SIDE6  = 3'd7;

   localparam logic [TAP_W-1:0]  TAP_COUNT_RESET = 3'd1;
   localparam logic [COEF_W-1:0] COEF_ONE        = 17'h10000;

   typedef logic [NUM_CH-1:0][PIX_W-1:0] pixel_type;

   // coef[0] is the centre weight, coef[i] the weight at distance i
   typedef struct packed {
      logic [TAP_W-1:0]                tap_count;
      logic [MAX_TAPS-1:0][COEF_W-1:0] coef;
   } cfg_type;

   typedef struct packed {
      pixel_type                                    centre;
      logic [MAX_SIDES-1:0][NUM_CH-1:0][PAIR_W-1:0] pair;
      logic                                         row_end;
      logic                                         run_end;
   } tap_type;

   // side taps in use; zero taps acts as one
   function automatic logic [PEND_W-1:0] side_count(input logic [TAP_W-1:0] taps);
      logic [PEND_W-1:0] sides;
      if (taps == '0) begin
         sides = '0;
      end else begin
         sides = PEND_W'(taps - TAP_W'(1));
      end
      return sides;
   endfunction

endpackage

// ===== src/rgb_row_symmetric_fir_clamped.sv =====
// Top level: symmetric RGB row FIR with edge clamp, register file and channel ports.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_in_red, req_in_green, req_in_blue,
//          |           |                       | req_row_end
//  rsp     | out       | rsp_valid / rsp_stall | rsp_out_red, rsp_out_green, rsp_out_blue,
//          |           |                       | rsp_out_row_end, rsp_last_in_run
//  csr     | in/out    | APB write/read        | 8 registers at byte address 4*index
//
// One pixel per cycle while each pixel releases at most one output; a pixel that
// releases more outputs (a row-end flush releases all that are pending) holds req_stall until
// its last is issued, set by the single gather/multiply path that forms one output per cycle.
// Accepted pixels reach rsp_valid through the sequencer state, tap register, product stage and result register.
// Synchronous reset clears control state and loads tap_count 1, centre weight 1.0.
// rsp_stall backs up through the result, product and tap registers; once all three are
// full, a pixel that releases an output holds req_stall until the stall clears.
module rgb_row_symmetric_fir_clamped (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rsf_pkg::PIX_W-1:0]    req_in_red,
   input  logic [rsf_pkg::PIX_W-1:0]    req_in_green,
   input  logic [rsf_pkg::PIX_W-1:0]    req_in_blue,
   input  logic                         req_row_end,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rsf_pkg::PIX_W-1:0]    rsp_out_red,
   output logic [rsf_pkg::PIX_W-1:0]    rsp_out_green,
   output logic [rsf_pkg::PIX_W-1:0]    rsp_out_blue,
   output logic                         rsp_out_row_end,
   output logic                         rsp_last_in_run,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rsf_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [rsf_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [rsf_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);

   rsf_pkg::cfg_type   cfg_ff, cfg_in;
   logic [2:0]         csr_idx;
   logic               csr_wr;
   rsf_pkg::pixel_type req_pixel, rsp_pixel;
   rsf_pkg::tap_type   tap;
   logic               tap_valid, tap_ready;

   assign csr_idx    = csr_paddr[rsf_pkg::ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            rsf_pkg::REG_TAP_COUNT:   cfg_in.tap_count = csr_pwdata[rsf_pkg::TAP_W-1:0];
            rsf_pkg::REG_COEF_CENTER: cfg_in.coef[0] = csr_pwdata[rsf_pkg::COEF_W-1:0];
            rsf_pkg::REG_COEF_SIDE1:  cfg_in.coef[1] = csr_pwdata[rsf_pkg::COEF_W-1:0];
            rsf_pkg::REG_COEF_SIDE2:  cfg_in.coef[2] = csr_pwdata[rsf_pkg::COEF_W-1:0];
            rsf_pkg::REG_COEF_SIDE3:  cfg_in.coef[3] = csr_pwdata[rsf_pkg::COEF_W-1:0];
            rsf_pkg::REG_COEF_SIDE4:  cfg_in.coef[4] = csr_pwdata[rsf_pkg::COEF_W-1:0];
            rsf_pkg::REG_COEF_SIDE5:  cfg_in.coef[5] = csr_pwdata[rsf_pkg::COEF_W-1:0];
            rsf_pkg::REG_COEF_SIDE6:  cfg_in.coef[6] = csr_pwdata[rsf_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         rsf_pkg::REG_TAP_COUNT:   csr_prdata = rsf_pkg::DATA_W'(cfg_ff.tap_count);
         rsf_pkg::REG_COEF_CENTER: csr_prdata = rsf_pkg::DATA_W'(cfg_ff.coef[0]);
         rsf_pkg::REG_COEF_SIDE1:  csr_prdata = rsf_pkg::DATA_W'(cfg_ff.coef[1]);
         rsf_pkg::REG_COEF_SIDE2:  csr_prdata = rsf_pkg::DATA_W'(cfg_ff.coef[2]);
         rsf_pkg::REG_COEF_SIDE3:  csr_prdata = rsf_pkg::DATA_W'(cfg_ff.coef[3]);
         rsf_pkg::REG_COEF_SIDE4:  csr_prdata = rsf_pkg::DATA_W'(cfg_ff.coef[4]);
         rsf_pkg::REG_COEF_SIDE5:  csr_prdata = rsf_pkg::DATA_W'(cfg_ff.coef[5]);
         rsf_pkg::REG_COEF_SIDE6:  csr_prdata = rsf_pkg::DATA_W'(cfg_ff.coef[6]);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_count <= rsf_pkg::TAP_COUNT_RESET;
         cfg_ff.coef      <= {{((rsf_pkg::MAX_TAPS - 1) * rsf_pkg::COEF_W){1'b0}},
                              rsf_pkg::COEF_ONE};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_pixel = {req_in_blue, req_in_green, req_in_red};

   rsf_window u_window (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pixel   (req_pixel),
      .req_row_end (req_row_end),
      .tap_ready   (tap_ready),
      .tap_valid   (tap_valid),
      .tap         (tap)
   );

   rsf_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .tap_valid   (tap_valid),
      .tap_ready   (tap_ready),
      .tap         (tap),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pixel   (rsp_pixel),
      .rsp_row_end (rsp_out_row_end),
      .rsp_run_end (rsp_last_in_run)
   );

   assign rsp_out_red   = rsp_pixel[0];
   assign rsp_out_green = rsp_pixel[1];
   assign rsp_out_blue  = rsp_pixel[2];

endmodule

// ===== src/rsf_window.sv =====
// Pixel window, row counters and the output sequencer that gathers tap pairs.
module rsf_window (
   input  logic              clock,
   input  logic              reset,
   input  rsf_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsf_pkg::pixel_type req_pixel,
   input  logic              req_row_end,
   input  logic              tap_ready,
   output logic              tap_valid,
   output rsf_pkg::tap_type  tap
);

   rsf_pkg::pixel_type win_ff [rsf_pkg::WIN_DEPTH];
   rsf_pkg::pixel_type win_in [rsf_pkg::WIN_DEPTH];
   logic [rsf_pkg::CNT_W-1:0]  seen_ff, seen_in, seen_mid;
   logic [rsf_pkg::CNT_W-1:0]  sent_ff, sent_in, sent_mid;
   logic [rsf_pkg::CNT_W-1:0]  diff;
   logic [rsf_pkg::PEND_W-1:0] pend_ff, pend_in, pend_dec, sides;
   logic                       busy_ff, busy_in;
   logic                       last_ff, last_in;
   logic                       tv_ff, tv_in;
   rsf_pkg::tap_type           tap_ff, tap_in;
   logic                       emit_ok, more, issue, finish, accept, s1_ready;
   logic [rsf_pkg::IDX_W-1:0]  start, centre;
   logic [rsf_pkg::IDX_W-1:0]  li [rsf_pkg::MAX_SIDES];
   logic [rsf_pkg::IDX_W-1:0]  ri [rsf_pkg::MAX_SIDES];

   // sequencer: one output per cycle while the current pixel still releases outputs and the tap register can take them
   always_comb begin
      sides    = rsf_pkg::side_count(cfg.tap_count);
      pend_dec = pend_ff - rsf_pkg::PEND_W'(1);
      emit_ok  = busy_ff && (pend_ff != '0) && (last_ff || (pend_ff > sides));
      more     = (pend_dec != '0) && (last_ff || (pend_dec > sides));
      s1_ready = !tv_ff || tap_ready;
      issue    = emit_ok && s1_ready;
      finish   = busy_ff && (!emit_ok || (issue && !more));
      req_stall = busy_ff && !finish;
      accept   = req_valid && !req_stall;

      seen_mid = seen_ff;
      sent_mid = sent_ff;
      pend_in  = pend_ff;
      if (issue) begin
         pend_in = pend_dec;
         if (sent_ff != '1) begin
            sent_mid = sent_ff + rsf_pkg::CNT_W'(1);
         end
      end
      if (finish && last_ff) begin
         seen_mid = '0;
         sent_mid = '0;
      end

      seen_in = seen_mid;
      sent_in = sent_mid;
      win_in  = win_ff;
      last_in = last_ff;
      busy_in = busy_ff && !finish;
      diff    = '0;
      if (accept) begin
         win_in[0] = req_pixel;
         for (int k = 1; k < rsf_pkg::WIN_DEPTH; k++) begin
            win_in[k] = win_ff[k-1];
         end
         if (seen_mid != '1) begin
            seen_in = seen_mid + rsf_pkg::CNT_W'(1);
         end else if (sent_mid != '0) begin
            sent_in = sent_mid - rsf_pkg::CNT_W'(1);
         end
         diff = seen_in - sent_in;
         if (diff > rsf_pkg::CNT_W'(7)) begin
            pend_in = '1;
         end else begin
            pend_in = diff[rsf_pkg::PEND_W-1:0];
         end
         last_in = req_row_end;
         busy_in = 1'b1;
      end
   end

   // tap gather for the oldest waiting pixel; left taps stop at the row start, right taps at the newest pixel
   always_comb begin
      if ((seen_ff == '0) || (seen_ff > rsf_pkg::CNT_W'(rsf_pkg::WIN_DEPTH))) begin
         start = rsf_pkg::IDX_W'(rsf_pkg::WIN_DEPTH - 1);
      end else begin
         start = seen_ff - rsf_pkg::CNT_W'(1);
      end
      centre = {1'b0, pend_dec};

      tap_in         = tap_ff;
      tap_in.centre  = win_ff[centre];
      tap_in.row_end = last_ff && !more;
      tap_in.run_end = !more;
      for (int i = 0; i < rsf_pkg::MAX_SIDES; i++) begin
         li[i] = centre + rsf_pkg::IDX_W'(i + 1);
         if (li[i] > start) begin
            li[i] = start;
         end
         if (rsf_pkg::IDX_W'(i + 1) > centre) begin
            ri[i] = '0;
         end else begin
            ri[i] = centre - rsf_pkg::IDX_W'(i + 1);
         end
         for (int ch = 0; ch < rsf_pkg::NUM_CH; ch++) begin
            tap_in.pair[i][ch] = {1'b0, win_ff[li[i]][ch]} + {1'b0, win_ff[ri[i]][ch]};
         end
      end
      tv_in = issue || (tv_ff && !tap_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         sent_ff <= '0;
         pend_ff <= '0;
         busy_ff <= 1'b0;
         last_ff <= 1'b0;
         tv_ff   <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         sent_ff <= sent_in;
         pend_ff <= pend_in;
         busy_ff <= busy_in;
         last_ff <= last_in;
         tv_ff   <= tv_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (issue) begin
         tap_ff <= tap_in;
      end
   end

   assign tap_valid = tv_ff;
   assign tap      = tap_ff;

endmodule

// ===== src/rsf_mac.sv =====
// Weight multiply stage, then sum, truncate and clamp into the result register.
module rsf_mac (
   input  logic               clock,
   input  logic               reset,
   input  rsf_pkg::cfg_type   cfg,
   input  logic               tap_valid,
   output logic               tap_ready,
   input  rsf_pkg::tap_type   tap,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsf_pkg::pixel_type rsp_pixel,
   output logic               rsp_row_end,
   output logic               rsp_run_end
);

   logic [rsf_pkg::CPROD_W-1:0] cprod_ff [rsf_pkg::NUM_CH];
   logic [rsf_pkg::CPROD_W-1:0] cprod_in [rsf_pkg::NUM_CH];
   logic [rsf_pkg::SPROD_W-1:0] sprod_ff [rsf_pkg::MAX_SIDES][rsf_pkg::NUM_CH];
   logic [rsf_pkg::SPROD_W-1:0] sprod_in [rsf_pkg::MAX_SIDES][rsf_pkg::NUM_CH];
   logic [rsf_pkg::COEF_W-1:0]  weight [rsf_pkg::MAX_SIDES];
   logic [rsf_pkg::SUM_W-1:0]   sum [rsf_pkg::NUM_CH];
   logic [rsf_pkg::PEND_W-1:0]  sides;
   logic                        pv_ff, prow_ff, prun_ff;
   logic                        ov_ff, orow_ff, orun_ff;
   rsf_pkg::pixel_type          opix_ff, opix_in;
   logic                        out_ready, p_ready;

   assign out_ready = !ov_ff || !rsp_stall;
   assign p_ready   = !pv_ff || out_ready;
   assign tap_ready = p_ready;

   // unused side taps weigh zero
   always_comb begin
      sides = rsf_pkg::side_count(cfg.tap_count);
      for (int s = 0; s < rsf_pkg::MAX_SIDES; s++) begin
         if (rsf_pkg::PEND_W'(s + 1) <= sides) begin
            weight[s] = cfg.coef[s+1];
         end else begin
            weight[s] = '0;
         end
      end
      for (int ch = 0; ch < rsf_pkg::NUM_CH; ch++) begin
         cprod_in[ch] = rsf_pkg::CPROD_W'(cfg.coef[0]) * rsf_pkg::CPROD_W'(tap.centre[ch]);
         for (int s = 0; s < rsf_pkg::MAX_SIDES; s++) begin
            sprod_in[s][ch] = rsf_pkg::SPROD_W'(weight[s]) * rsf_pkg::SPROD_W'(tap.pair[s][ch]);
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < rsf_pkg::NUM_CH; ch++) begin
         sum[ch] = rsf_pkg::SUM_W'(cprod_ff[ch]);
         for (int s = 0; s < rsf_pkg::MAX_SIDES; s++) begin
            sum[ch] = sum[ch] + rsf_pkg::SUM_W'(sprod_ff[s][ch]);
         end
         if (sum[ch][rsf_pkg::SUM_W-1:rsf_pkg::FRAC_W+rsf_pkg::PIX_W] != '0) begin
            opix_in[ch] = '1;
         end else begin
            opix_in[ch] = sum[ch][rsf_pkg::FRAC_W+rsf_pkg::PIX_W-1:rsf_pkg::FRAC_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (p_ready) begin
            pv_ff <= tap_valid;
         end
         if (out_ready) begin
            ov_ff <= pv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready && tap_valid) begin
         cprod_ff <= cprod_in;
         sprod_ff <= sprod_in;
         prow_ff  <= tap.row_end;
         prun_ff  <= tap.run_end;
      end
      if (out_ready && pv_ff) begin
         opix_ff <= opix_in;
         orow_ff <= prow_ff;
         orun_ff <= prun_ff;
      end
   end

   assign rsp_valid   = ov_ff;
   assign rsp_pixel   = opix_ff;
   assign rsp_row_end = orow_ff;
   assign rsp_run_end = orun_ff;

endmodule
